// ===== design/vgmcsp_pkg.sv =====
// ---------------------------------------------------------------------------
// vgmcsp_pkg
// shared command codes, result kinds and the queue record of the parser
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vgmcsp_pkg;

  localparam logic [7:0] CMD_WR_P0_A   = 8'h5E;
  localparam logic [7:0] CMD_WR_P0_B   = 8'h56;
  localparam logic [7:0] CMD_WR_P1_A   = 8'h5F;
  localparam logic [7:0] CMD_WR_P1_B   = 8'h57;
  localparam logic [7:0] CMD_WAIT_N    = 8'h61;
  localparam logic [7:0] CMD_WAIT_NTSC = 8'h62;
  localparam logic [7:0] CMD_WAIT_PAL  = 8'h63;
  localparam logic [7:0] CMD_END       = 8'h66;
  localparam logic [7:0] CMD_WAIT_SH_LO = 8'h70;
  localparam logic [7:0] CMD_WAIT_SH_HI = 8'h7F;

  localparam logic [15:0] WAIT_NTSC_SAMPLES = 16'd735;
  localparam logic [15:0] WAIT_PAL_SAMPLES  = 16'd882;
  localparam logic [31:0] LOOP_HDR_BIAS     = 32'h0000_001C;

  typedef enum logic [2:0] {
    KIND_WRITE = 3'd0,
    KIND_WAIT  = 3'd1,
    KIND_SEEK  = 3'd2,
    KIND_END   = 3'd3,
    KIND_BAD   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] cmd;
    logic [7:0] op0;
    logic [7:0] op1;
  } cmd_rec_t;

endpackage

`default_nettype wire

// ===== design/vgmcsp_front.sv =====
// ---------------------------------------------------------------------------
// vgmcsp_front
// byte parser: tracks operand phase and classifies each finished command
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vgmcsp_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                byte_vld,
  input  wire logic [7:0]          byte_in,
  input  wire logic                loop_set,
  output vgmcsp_pkg::cmd_rec_t     rec,
  output logic                     rec_push
);

  typedef enum logic [1:0] {
    PH_CMD = 2'd0,
    PH_OP1 = 2'd1,
    PH_OP2 = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic [7:0] first_r, first_nxt;
  logic       loop_taken_r, loop_taken_nxt;
  logic       halted_r, halted_nxt;

  always_comb begin
    phase_nxt      = phase_r;
    held_nxt       = held_r;
    first_nxt      = first_r;
    loop_taken_nxt = loop_taken_r;
    halted_nxt     = halted_r;
    rec_push       = 1'b0;
    rec.kind       = vgmcsp_pkg::KIND_BAD;
    rec.cmd        = byte_in;
    rec.op0        = first_r;
    rec.op1        = byte_in;
    if (byte_vld && !halted_r) begin
      unique case (phase_r)
        PH_OP1: begin
          first_nxt = byte_in;
          phase_nxt = PH_OP2;
        end
        PH_OP2: begin
          phase_nxt = PH_CMD;
          rec_push  = 1'b1;
          rec.cmd   = held_r;
          rec.kind  = (held_r == vgmcsp_pkg::CMD_WAIT_N) ? vgmcsp_pkg::KIND_WAIT
                                                         : vgmcsp_pkg::KIND_WRITE;
        end
        default: begin
          phase_nxt = PH_CMD;
          held_nxt  = byte_in;
          unique case (byte_in) inside
            vgmcsp_pkg::CMD_WR_P0_A, vgmcsp_pkg::CMD_WR_P0_B,
            vgmcsp_pkg::CMD_WR_P1_A, vgmcsp_pkg::CMD_WR_P1_B,
            vgmcsp_pkg::CMD_WAIT_N: begin
              phase_nxt = PH_OP1;
            end
            vgmcsp_pkg::CMD_WAIT_NTSC, vgmcsp_pkg::CMD_WAIT_PAL,
            [vgmcsp_pkg::CMD_WAIT_SH_LO:vgmcsp_pkg::CMD_WAIT_SH_HI]: begin
              rec_push = 1'b1;
              rec.kind = vgmcsp_pkg::KIND_WAIT;
            end
            vgmcsp_pkg::CMD_END: begin
              rec_push = 1'b1;
              if (loop_set && !loop_taken_r) begin
                loop_taken_nxt = 1'b1;
                rec.kind       = vgmcsp_pkg::KIND_SEEK;
              end else begin
                halted_nxt = 1'b1;
                rec.kind   = vgmcsp_pkg::KIND_END;
              end
            end
            default: begin
              rec_push   = 1'b1;
              halted_nxt = 1'b1;
              rec.kind   = vgmcsp_pkg::KIND_BAD;
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_CMD;
      held_r       <= '0;
      first_r      <= '0;
      loop_taken_r <= 1'b0;
      halted_r     <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      held_r       <= held_nxt;
      first_r      <= first_nxt;
      loop_taken_r <= loop_taken_nxt;
      halted_r     <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/vgmcsp_fifo.sv =====
// ---------------------------------------------------------------------------
// vgmcsp_fifo
// two-entry queue of command records between the parser and the back end
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vgmcsp_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire vgmcsp_pkg::cmd_rec_t wr_data,
  output logic                      wr_full,
  input  wire logic                 rd_en,
  output vgmcsp_pkg::cmd_rec_t      rd_data,
  output logic                      rd_empty
);

  vgmcsp_pkg::cmd_rec_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign wr_full  = (cnt_r == 2'd2);
  assign rd_empty = (cnt_r == 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !wr_full;
  assign do_rd    = rd_en && !rd_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_wr;
    rd_ptr_nxt = rd_ptr_r ^ do_rd;
    cnt_nxt    = cnt_r;
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/vgmcsp_back.sv =====
// ---------------------------------------------------------------------------
// vgmcsp_back
// expands queued command records into result fields in the output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vgmcsp_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire vgmcsp_pkg::cmd_rec_t rec,
  input  wire logic                 rec_empty,
  output logic                      rec_pop,
  input  wire logic [31:0]          loop_base,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [2:0]                out_result_kind,
  output logic                      out_port_select,
  output logic [7:0]                out_register_address,
  output logic [7:0]                out_register_value,
  output logic [15:0]               out_wait_samples,
  output logic [31:0]               out_seek_address,
  output logic [7:0]                out_bad_command
);

  logic        vld_r, vld_nxt;
  logic [2:0]  kind_nxt;
  logic        port_nxt;
  logic [7:0]  addr_nxt, val_nxt, bad_nxt;
  logic [15:0] wait_nxt;
  logic [31:0] seek_nxt;

  assign empty   = !vld_r;
  assign rec_pop = !rec_empty && (!vld_r || pop);

  always_comb begin
    vld_nxt  = rec_pop ? 1'b1 : (vld_r && !pop);
    kind_nxt = rec.kind;
    port_nxt = 1'b0;
    addr_nxt = '0;
    val_nxt  = '0;
    wait_nxt = '0;
    seek_nxt = '0;
    bad_nxt  = '0;
    unique case (rec.kind)
      vgmcsp_pkg::KIND_WRITE: begin
        port_nxt = (rec.cmd == vgmcsp_pkg::CMD_WR_P1_A) ||
                   (rec.cmd == vgmcsp_pkg::CMD_WR_P1_B);
        addr_nxt = rec.op0;
        val_nxt  = rec.op1;
      end
      vgmcsp_pkg::KIND_WAIT: begin
        unique case (rec.cmd)
          vgmcsp_pkg::CMD_WAIT_N:    wait_nxt = {rec.op1, rec.op0};
          vgmcsp_pkg::CMD_WAIT_NTSC: wait_nxt = vgmcsp_pkg::WAIT_NTSC_SAMPLES;
          vgmcsp_pkg::CMD_WAIT_PAL:  wait_nxt = vgmcsp_pkg::WAIT_PAL_SAMPLES;
          default:                   wait_nxt = {12'd0, rec.cmd[3:0]} + 16'd1;
        endcase
      end
      vgmcsp_pkg::KIND_SEEK: begin
        seek_nxt = loop_base + vgmcsp_pkg::LOOP_HDR_BIAS;
      end
      vgmcsp_pkg::KIND_BAD: begin
        bad_nxt = rec.cmd;
      end
      default: begin
        kind_nxt = rec.kind;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      out_result_kind      <= kind_nxt;
      out_port_select      <= port_nxt;
      out_register_address <= addr_nxt;
      out_register_value   <= val_nxt;
      out_wait_samples     <= wait_nxt;
      out_seek_address     <= seek_nxt;
      out_bad_command      <= bad_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/vgm_command_stream_parser_top.sv =====
// ---------------------------------------------------------------------------
// vgm_command_stream_parser_top
// command stream parser for a register-write music stream
//
// input channel: one stream byte per item on in_stream_byte, taken at a
// clock edge with push high and full low. result channel: the oldest result
// sits on the out_ ports while empty is low and leaves at an edge with pop
// high. cfg_wr_en writes cfg_loop_start_offset (zero means no loop).
// a byte that finishes a command shows its result on the out_ ports after
// the queue and the output register: the parser pushes a record into a
// two-entry queue, and the back end loads it into the output register
// when that is free or popped. one byte is taken every cycle while the
// receiver keeps up; operand bytes give no result.
// when pop is held low the queue fills behind the output register and full
// rises once it holds two records; parsing resumes as soon as one drains.
// reset clears the parse phase, the loop and halt flags and the loop offset,
// and empties the queue and the output register. after an unknown command,
// or an end with no loop seek, the parser ignores every byte until reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vgm_command_stream_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_stream_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       out_result_kind,
  output logic             out_port_select,
  output logic [7:0]       out_register_address,
  output logic [7:0]       out_register_value,
  output logic [15:0]      out_wait_samples,
  output logic [31:0]      out_seek_address,
  output logic [7:0]       out_bad_command,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_loop_start_offset
);

  logic [31:0]          loop_base_r;
  logic                 byte_vld;
  vgmcsp_pkg::cmd_rec_t front_rec;
  logic                 front_push;
  vgmcsp_pkg::cmd_rec_t back_rec;
  logic                 back_empty;
  logic                 back_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_base_r <= '0;
    end else if (cfg_wr_en) begin
      loop_base_r <= cfg_loop_start_offset;
    end
  end

  assign byte_vld = push && !full;

  vgmcsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (byte_vld),
    .byte_in  (in_stream_byte),
    .loop_set (loop_base_r != 32'd0),
    .rec      (front_rec),
    .rec_push (front_push)
  );

  vgmcsp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (front_push),
    .wr_data  (front_rec),
    .wr_full  (full),
    .rd_en    (back_pop),
    .rd_data  (back_rec),
    .rd_empty (back_empty)
  );

  vgmcsp_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .rec                  (back_rec),
    .rec_empty            (back_empty),
    .rec_pop              (back_pop),
    .loop_base            (loop_base_r),
    .empty                (empty),
    .pop                  (pop),
    .out_result_kind      (out_result_kind),
    .out_port_select      (out_port_select),
    .out_register_address (out_register_address),
    .out_register_value   (out_register_value),
    .out_wait_samples     (out_wait_samples),
    .out_seek_address     (out_seek_address),
    .out_bad_command      (out_bad_command)
  );

endmodule

`default_nettype wire
